>>> hdl/ffa_pkg.sv
package ffa_pkg;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int HDR_W     = 8;
    localparam int CFG_IDX_W = 4;
    localparam int STEP_W    = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = CFG_IDX_W'(1);

    // Reset values of the configuration registers
    localparam logic [DATA_W-1:0] HEAP_LIMIT_RST   = 32'd65536;
    localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 8'd24;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_ZERO_SIZE       = 3'd1,
        ST_HEAP_EXHAUSTED  = 3'd2,
        ST_TABLE_FULL      = 3'd3,
        ST_UNKNOWN_ADDRESS = 3'd4,
        ST_DOUBLE_FREE     = 3'd5
    } status_t;

    // One block table entry
    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] bytes;
        logic              is_free;
    } entry_t;

    // Datapath operations selected by the control word
    typedef enum logic [2:0] {
        A_NONE,
        A_LOAD,
        A_SCAN,
        A_APPEND,
        A_TAKE,
        A_MARK,
        A_RES,
        A_PUT
    } action_t;

    // Branch conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_IS_FREE,
        C_SIZE_ZERO,
        C_ADDR_NULL,
        C_HIT,
        C_SCAN_BUSY,
        C_HEAP_OVER,
        C_TABLE_FULL,
        C_HIT_FREE,
        C_OUT_CAN
    } cond_t;

    // Control word: jump to target on jump_cond, else hold on stay_cond, else advance
    typedef struct packed {
        action_t             action;
        status_t             status;
        cond_t               jump_cond;
        cond_t               stay_cond;
        logic [STEP_W-1:0]   target;
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic no_req;
        logic is_free;
        logic size_zero;
        logic addr_null;
        logic hit;
        logic scan_busy;
        logic heap_over;
        logic table_full;
        logic hit_free;
        logic out_can;
    } flags_t;

endpackage

>>> hdl/ffa_req_if.sv
interface ffa_req_if;
    import ffa_pkg::*;

    logic              valid;
    logic              ready;
    op_t               operation;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] payload_address;

    modport source (output valid, output operation, output request_size,
                    output payload_address, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input payload_address, output ready);
endinterface

>>> hdl/ffa_rsp_if.sv
interface ffa_rsp_if;
    import ffa_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [DATA_W-1:0] result_address;

    modport source (output valid, output status, output result_address, input ready);
    modport sink   (input valid, input status, input result_address, output ready);
endinterface

>>> hdl/ffa_cfg_if.sv
interface ffa_cfg_if;
    import ffa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/ffa_seq.sv
module ffa_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  ffa_pkg::flags_t flags,
    output ffa_pkg::ctrl_t  ctrl
);
    import ffa_pkg::*;

    typedef enum logic [STEP_W-1:0] {
        S_FETCH,
        S_DISPATCH,
        S_A_ZERO,
        S_A_SCAN,
        S_A_HEAP,
        S_A_FULL,
        S_A_APPEND,
        S_F_NULL,
        S_F_SCAN,
        S_F_UNKNOWN,
        S_F_HIT,
        S_F_MARK,
        S_A_TAKE,
        S_R_ZERO,
        S_R_HEAP,
        S_R_FULL,
        S_R_DOUBLE,
        S_R_OK,
        S_PUT
    } step_t;

    step_t pc_reg;
    step_t pc_next;
    logic  jump_hit;
    logic  stay_hit;

    function automatic ctrl_t mk(action_t a, status_t s, cond_t jc, cond_t sc, step_t t);
        ctrl_t w;
        w.action    = a;
        w.status    = s;
        w.jump_cond = jc;
        w.stay_cond = sc;
        w.target    = t;
        return w;
    endfunction

    // Microprogram
    function automatic ctrl_t rom(step_t s);
        ctrl_t w;
        case (s)
            S_FETCH:     w = mk(A_LOAD,   ST_OK, C_NEVER,      C_NO_REQ,    S_FETCH);
            S_DISPATCH:  w = mk(A_NONE,   ST_OK, C_IS_FREE,    C_NEVER,     S_F_NULL);
            // allocate path
            S_A_ZERO:    w = mk(A_NONE,   ST_OK, C_SIZE_ZERO,  C_NEVER,     S_R_ZERO);
            S_A_SCAN:    w = mk(A_SCAN,   ST_OK, C_HIT,        C_SCAN_BUSY, S_A_TAKE);
            S_A_HEAP:    w = mk(A_NONE,   ST_OK, C_HEAP_OVER,  C_NEVER,     S_R_HEAP);
            S_A_FULL:    w = mk(A_NONE,   ST_OK, C_TABLE_FULL, C_NEVER,     S_R_FULL);
            S_A_APPEND:  w = mk(A_APPEND, ST_OK, C_ALWAYS,     C_NEVER,     S_PUT);
            // free path
            S_F_NULL:    w = mk(A_NONE,   ST_OK, C_ADDR_NULL,  C_NEVER,     S_R_OK);
            S_F_SCAN:    w = mk(A_SCAN,   ST_OK, C_HIT,        C_SCAN_BUSY, S_F_HIT);
            S_F_UNKNOWN: w = mk(A_RES, ST_UNKNOWN_ADDRESS, C_ALWAYS, C_NEVER, S_PUT);
            S_F_HIT:     w = mk(A_NONE,   ST_OK, C_HIT_FREE,   C_NEVER,     S_R_DOUBLE);
            S_F_MARK:    w = mk(A_MARK,   ST_OK, C_ALWAYS,     C_NEVER,     S_PUT);
            // reuse of a free block
            S_A_TAKE:    w = mk(A_TAKE,   ST_OK, C_ALWAYS,     C_NEVER,     S_PUT);
            // plain results
            S_R_ZERO:    w = mk(A_RES, ST_ZERO_SIZE,      C_ALWAYS, C_NEVER, S_PUT);
            S_R_HEAP:    w = mk(A_RES, ST_HEAP_EXHAUSTED, C_ALWAYS, C_NEVER, S_PUT);
            S_R_FULL:    w = mk(A_RES, ST_TABLE_FULL,     C_ALWAYS, C_NEVER, S_PUT);
            S_R_DOUBLE:  w = mk(A_RES, ST_DOUBLE_FREE,    C_ALWAYS, C_NEVER, S_PUT);
            S_R_OK:      w = mk(A_RES, ST_OK,             C_ALWAYS, C_NEVER, S_PUT);
            // hand result to the output register
            S_PUT:       w = mk(A_PUT,    ST_OK, C_OUT_CAN,    C_ALWAYS,    S_FETCH);
            default:     w = mk(A_NONE,   ST_OK, C_ALWAYS,     C_NEVER,     S_FETCH);
        endcase
        return w;
    endfunction

    function automatic logic cond_true(cond_t c, flags_t f);
        logic r;
        case (c)
            C_NEVER:      r = 1'b0;
            C_ALWAYS:     r = 1'b1;
            C_NO_REQ:     r = f.no_req;
            C_IS_FREE:    r = f.is_free;
            C_SIZE_ZERO:  r = f.size_zero;
            C_ADDR_NULL:  r = f.addr_null;
            C_HIT:        r = f.hit;
            C_SCAN_BUSY:  r = f.scan_busy;
            C_HEAP_OVER:  r = f.heap_over;
            C_TABLE_FULL: r = f.table_full;
            C_HIT_FREE:   r = f.hit_free;
            C_OUT_CAN:    r = f.out_can;
            default:      r = 1'b0;
        endcase
        return r;
    endfunction

    assign ctrl     = rom(pc_reg);
    assign jump_hit = cond_true(ctrl.jump_cond, flags);
    assign stay_hit = cond_true(ctrl.stay_cond, flags);

    // Next step: jump, hold or advance
    always_comb
    begin
        if (jump_hit)
        begin
            pc_next = step_t'(ctrl.target);
        end
        else if (stay_hit)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = step_t'(STEP_W'(pc_reg + STEP_W'(1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hdl/ffa_dp.sv
module ffa_dp #(
    parameter int MAX_BLOCKS = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ffa_pkg::ctrl_t                 ctrl,
    output ffa_pkg::flags_t                flags,
    input  logic [ffa_pkg::DATA_W-1:0]     heap_limit,
    input  logic [ffa_pkg::HDR_W-1:0]      header_bytes,
    ffa_req_if.sink                        req,
    ffa_rsp_if.source                      rsp
);
    import ffa_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int TOP_W = DATA_W + 2;

    // Block table
    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;

    // Control state
    logic             rd_vld_reg,   rd_vld_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0] used_reg,     used_next;
    logic [DATA_W-1:0] heap_top_reg, heap_top_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state
    op_t               op_reg,         op_next;
    logic [DATA_W-1:0] size_reg,       size_next;
    logic [DATA_W-1:0] addr_reg,       addr_next;
    logic [IDX_W-1:0]  rd_idx_reg,     rd_idx_next;
    entry_t            hit_ent_reg,    hit_ent_next;
    logic [IDX_W-1:0]  hit_idx_reg,    hit_idx_next;
    status_t           res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_addr_reg,   res_addr_next;
    status_t           out_status_reg, out_status_next;
    logic [DATA_W-1:0] out_addr_reg,   out_addr_next;

    // Memory port controls
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    entry_t            wr_data;
    logic              rd_en;

    // Datapath terms
    logic              accept;
    logic [TOP_W-1:0]  new_top;
    logic [DATA_W-1:0] new_payload;
    logic [DATA_W:0]   cand_payload;
    logic              match_free;
    logic              fit;
    logic              hit;
    logic              scan_more;
    logic              out_can;
    logic              heap_over;

    assign req.ready = (ctrl.action == A_LOAD);
    assign accept    = req.valid && req.ready;

    // Growth: new top = top + header + size, checked against limit and address range
    assign new_top     = {2'b00, heap_top_reg} + TOP_W'(header_bytes) + {2'b00, size_reg};
    assign new_payload = heap_top_reg + DATA_W'(header_bytes);
    assign heap_over   = (new_top > {2'b00, heap_limit}) || ((new_top >> ADDR_WIDTH) != '0);

    // Compare of the entry read last cycle
    assign cand_payload = {1'b0, rd_data_reg.start} + (DATA_W+1)'(header_bytes);
    assign match_free   = (cand_payload == {1'b0, addr_reg});
    assign fit          = rd_data_reg.is_free && (rd_data_reg.bytes >= size_reg);
    assign hit          = rd_vld_reg && ((op_reg == OP_FREE) ? match_free : fit);
    assign scan_more    = (scan_idx_reg < used_reg);
    assign out_can      = !out_valid_reg || rsp.ready;

    assign flags.no_req     = !req.valid;
    assign flags.is_free    = (op_reg == OP_FREE);
    assign flags.size_zero  = (size_reg == '0);
    assign flags.addr_null  = (addr_reg == '0);
    assign flags.hit        = hit;
    assign flags.scan_busy  = scan_more || rd_vld_reg;
    assign flags.heap_over  = heap_over;
    assign flags.table_full = (used_reg >= CNT_W'(MAX_BLOCKS));
    assign flags.hit_free   = hit_ent_reg.is_free;
    assign flags.out_can    = out_can;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_address = out_addr_reg;

    // Action decode
    always_comb
    begin
        rd_vld_next     = rd_vld_reg;
        scan_idx_next   = scan_idx_reg;
        used_next       = used_reg;
        heap_top_next   = heap_top_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        rd_idx_next     = rd_idx_reg;
        hit_ent_next    = hit_ent_reg;
        hit_idx_next    = hit_idx_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        wr_en           = 1'b0;
        wr_idx          = hit_idx_reg;
        wr_data         = hit_ent_reg;
        rd_en           = 1'b0;

        // drain output register
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctrl.action)
            A_LOAD:
            begin
                if (accept)
                begin
                    op_next       = req.operation;
                    size_next     = req.request_size;
                    addr_next     = req.payload_address;
                    scan_idx_next = '0;
                    rd_vld_next   = 1'b0;
                end
            end
            A_SCAN:
            begin
                rd_en       = scan_more;
                rd_vld_next = scan_more;
                rd_idx_next = scan_idx_reg[IDX_W-1:0];
                if (scan_more)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    hit_ent_next = rd_data_reg;
                    hit_idx_next = rd_idx_reg;
                end
            end
            A_APPEND:
            begin
                wr_en           = 1'b1;
                wr_idx          = used_reg[IDX_W-1:0];
                wr_data.start   = heap_top_reg;
                wr_data.bytes   = size_reg;
                wr_data.is_free = 1'b0;
                used_next       = used_reg + CNT_W'(1);
                heap_top_next   = new_top[DATA_W-1:0];
                res_status_next = ST_OK;
                res_addr_next   = new_payload;
            end
            A_TAKE:
            begin
                wr_en           = 1'b1;
                wr_data.is_free = 1'b0;
                res_status_next = ST_OK;
                res_addr_next   = hit_ent_reg.start + DATA_W'(header_bytes);
            end
            A_MARK:
            begin
                wr_en           = 1'b1;
                wr_data.is_free = 1'b1;
                res_status_next = ST_OK;
                res_addr_next   = '0;
            end
            A_RES:
            begin
                res_status_next = ctrl.status;
                res_addr_next   = '0;
            end
            A_PUT:
            begin
                if (out_can)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            scan_idx_reg  <= '0;
            used_reg      <= '0;
            heap_top_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg    <= rd_vld_next;
            scan_idx_reg  <= scan_idx_next;
            used_reg      <= used_next;
            heap_top_reg  <= heap_top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        rd_idx_reg     <= rd_idx_next;
        hit_ent_reg    <= hit_ent_next;
        hit_idx_reg    <= hit_idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

endmodule

>>> hdl/first_fit_block_allocator.sv
// Channel  Dir  Payload                                         Transaction
// req      in   operation, request_size, payload_address        valid && ready
// rsp      out  status, result_address                          valid && ready
// cfg      in   index, data (0 heap_limit, 1 header_bytes)      valid && ready (ready tied high)
//
// One request at a time: the search reads one table entry per cycle from block memory
// on its way from the accept to the result register; the worst case is a full table
// with no fit, and a stall on rsp can delay the result further.
// Reset clears the block count and heap top; the table itself needs no clearing.
// A result waiting on rsp does not stop the next request from being taken;
// it only holds the following result until rsp drains.
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    ffa_req_if.sink    req,
    ffa_rsp_if.source  rsp,
    ffa_cfg_if.sink    cfg
);
    import ffa_pkg::*;

    logic [DATA_W-1:0] heap_limit_reg, heap_limit_next;
    logic [HDR_W-1:0]  header_reg,     header_next;
    logic              cfg_fire;
    ctrl_t             ctrl;
    flags_t            flags;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    // Configuration writes; a header of zero is taken as one
    always_comb
    begin
        heap_limit_next = heap_limit_reg;
        header_next     = header_reg;
        if (cfg_fire)
        begin
            case (cfg.index)
                REG_HEAP_LIMIT:
                begin
                    heap_limit_next = cfg.data;
                end
                REG_HEADER_BYTES:
                begin
                    header_next = (cfg.data[HDR_W-1:0] == '0) ? HDR_W'(1)
                                                              : cfg.data[HDR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= HEAP_LIMIT_RST;
            header_reg     <= HEADER_BYTES_RST;
        end
        else
        begin
            heap_limit_reg <= heap_limit_next;
            header_reg     <= header_next;
        end
    end

    ffa_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    ffa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .flags        (flags),
        .heap_limit   (heap_limit_reg),
        .header_bytes (header_reg),
        .req          (req),
        .rsp          (rsp)
    );

    // Header is never zero, so no payload lands at address zero
    a_header_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        header_reg != '0)
        else $error("header_bytes register is zero");

    // A zero header write reads back as one
    a_header_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_fire && cfg.index == REG_HEADER_BYTES && cfg.data[HDR_W-1:0] == '0)
        |=> header_reg == HDR_W'(1))
        else $error("zero header write not promoted to one");

    // Sequencer leaves fetch once a request is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second request taken before the first finished");

endmodule
